[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property that must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/deq_pkg.sv]
// types, codes and sizes shared by the deque cell row and its top level
package deq_pkg;

    // storage sizes
    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // transaction field widths
    localparam int OP_W     = 3;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int ELEM_W   = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_SECOND = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ONE   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [VAL_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0]    removed_value;
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    front_value;
        logic [VAL_W-1:0]    back_value;
        logic [ELEM_W-1:0]   element_count;
    } t_out_item;

    // command broadcast to every cell, at most one bit set
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic rem_second;
    } t_cell_cmd;

    // what one cell shows its neighbours
    typedef struct packed {
        logic                  valid;
        logic [WORD_WIDTH-1:0] data;
    } t_cell_link;

endpackage

[rtl/core/deq_cell.sv]
// one storage cell of the deque row, front at cell zero
module deq_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  deq_pkg::t_cell_cmd             i_cmd,
    input  logic [deq_pkg::WORD_WIDTH-1:0] i_push_word,
    input  deq_pkg::t_cell_link            i_left,
    input  deq_pkg::t_cell_link            i_right,
    input  logic                           i_right2_valid,
    output deq_pkg::t_cell_link            o_cell,
    output logic [deq_pkg::WORD_WIDTH-1:0] o_last_word,
    output logic [deq_pkg::WORD_WIDTH-1:0] o_second_word
);
    import deq_pkg::*;

    logic                  r_valid;
    logic                  n_valid;
    logic [WORD_WIDTH-1:0] r_data;
    logic [WORD_WIDTH-1:0] n_data;
    logic                  is_last;
    logic                  is_second;

    // position of this cell relative to the back
    assign is_last   = r_valid & ~i_right.valid;
    assign is_second = r_valid & i_right.valid & ~i_right2_valid;

    // next contents from the broadcast command and the neighbours
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_cmd.push_front) begin
            n_valid = i_left.valid;
            n_data  = i_left.data;
        end else if (i_cmd.push_back) begin
            if (!r_valid && i_left.valid) begin
                n_valid = 1'b1;
                n_data  = i_push_word;
            end
        end else if (i_cmd.pop_front) begin
            n_valid = i_right.valid;
            n_data  = i_right.data;
        end else if (i_cmd.pop_back) begin
            if (is_last) begin
                n_valid = 1'b0;
            end
        end else if (i_cmd.rem_second) begin
            if (is_second) begin
                n_data = i_right.data;
            end
            if (is_last) begin
                n_valid = 1'b0;
            end
        end
    end

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // stored word
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_cell.valid  = r_valid;
    assign o_cell.data   = r_data;
    assign o_last_word   = r_data & {WORD_WIDTH{is_last}};
    assign o_second_word = r_data & {WORD_WIDTH{is_second}};

endmodule

[rtl/core/double_ended_queue_unit.sv]
// bounded deque top level: operation decode, cell row and result register
// Bounded double-ended queue of DEPTH words held in a row of cells with the front
// word always in cell zero. At acceptance the whole cell row shifts or updates in
// one step and the removed word is captured; afterwards the front, back and count
// are read off the row into the output register, once that register is free. A
// new operation is accepted only after the previous one has been loaded into the
// output register; a stalled result holds back at most one further operation. No
// clearing pass is needed after reset: cell occupancy flags are cleared at once.
`include "assert_macros.svh"

module double_ended_queue_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  deq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output deq_pkg::t_out_item o_out_item
);
    import deq_pkg::*;

    logic                  r_pend;
    logic                  n_pend;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_out_item             r_out;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [WORD_WIDTH-1:0] r_removed;
    logic [STATUS_W-1:0]   r_status;

    logic                  in_acc;
    logic                  out_load;
    logic                  is_empty;
    logic                  is_full;
    t_cell_cmd             dec_cmd;
    t_cell_cmd             cell_cmd;
    logic [STATUS_W-1:0]   dec_status;
    logic [WORD_WIDTH-1:0] dec_removed;
    logic [WORD_WIDTH-1:0] push_word;
    logic [WORD_WIDTH-1:0] back_word;
    logic [WORD_WIDTH-1:0] second_word;
    logic [WORD_WIDTH-1:0] front_word;
    logic [DEPTH-1:0]      valid_vec;

    t_cell_link            cell_q [DEPTH];
    logic [WORD_WIDTH-1:0] last_w [DEPTH];
    logic [WORD_WIDTH-1:0] sec_w  [DEPTH];

    // handshake
    assign in_acc     = i_in_valid & ~r_pend;
    assign o_in_stall = r_pend;
    assign out_load   = r_pend & (~r_out_valid | ~i_out_stall);

    assign is_empty  = (r_count == '0);
    assign is_full   = (r_count == CNT_W'(DEPTH));
    assign push_word = WORD_WIDTH'(i_in_item.push_value);

    // operation decode against the current occupancy
    always_comb begin
        dec_cmd     = '0;
        dec_status  = ST_OK;
        dec_removed = '0;
        case (i_in_item.operation)
            OP_PUSH_FRONT: begin
                if (is_full) dec_status = ST_FULL;
                else         dec_cmd.push_front = 1'b1;
            end
            OP_PUSH_BACK: begin
                if (is_full) dec_status = ST_FULL;
                else         dec_cmd.push_back = 1'b1;
            end
            OP_POP_FRONT: begin
                if (is_empty) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_cmd.pop_front = 1'b1;
                    dec_removed       = cell_q[0].data;
                end
            end
            OP_POP_BACK: begin
                if (is_empty) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_cmd.pop_back = 1'b1;
                    dec_removed      = back_word;
                end
            end
            OP_REM_SECOND: begin
                if (is_empty) begin
                    dec_status = ST_EMPTY;
                end else if (r_count == CNT_W'(1)) begin
                    dec_status = ST_ONE;
                end else if (r_count == CNT_W'(2)) begin
                    dec_cmd.pop_front = 1'b1;
                    dec_removed       = cell_q[0].data;
                end else begin
                    dec_cmd.rem_second = 1'b1;
                    dec_removed        = second_word;
                end
            end
            default: begin
                dec_cmd = '0;
            end
        endcase
    end

    assign cell_cmd = in_acc ? dec_cmd : '0;

    // occupancy count follows the command
    always_comb begin
        n_count = r_count;
        if (cell_cmd.push_front || cell_cmd.push_back) begin
            n_count = r_count + CNT_W'(1);
        end else if (cell_cmd.pop_front || cell_cmd.pop_back || cell_cmd.rem_second) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // row of cells, each linked to its neighbours
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_link left_link;
        t_cell_link right_link;
        logic       right2_valid;

        if (g == 0) begin : g_head
            assign left_link.valid = 1'b1;
            assign left_link.data  = push_word;
        end else begin : g_mid
            assign left_link = cell_q[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_link = '0;
        end else begin : g_inner
            assign right_link = cell_q[g+1];
        end

        if (g + 2 < DEPTH) begin : g_r2
            assign right2_valid = cell_q[g+2].valid;
        end else begin : g_r2_edge
            assign right2_valid = 1'b0;
        end

        deq_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_cmd          (cell_cmd),
            .i_push_word    (push_word),
            .i_left         (left_link),
            .i_right        (right_link),
            .i_right2_valid (right2_valid),
            .o_cell         (cell_q[g]),
            .o_last_word    (last_w[g]),
            .o_second_word  (sec_w[g])
        );

        assign valid_vec[g] = cell_q[g].valid;
    end

    // back and second-last words, one cell selected in each
    always_comb begin
        back_word   = '0;
        second_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            back_word   = back_word | last_w[k];
            second_word = second_word | sec_w[k];
        end
    end

    assign front_word = cell_q[0].data & {WORD_WIDTH{cell_q[0].valid}};

    // control state
    always_comb begin
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_pend      = 1'b0;
            n_out_valid = 1'b1;
        end
        if (in_acc) begin
            n_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    // captured at acceptance, and the result register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_removed <= dec_removed;
            r_status  <= dec_status;
        end
        if (out_load) begin
            r_out.removed_value <= VAL_W'(r_removed);
            r_out.status        <= r_status;
            r_out.front_value   <= VAL_W'(front_word);
            r_out.back_value    <= VAL_W'(back_word);
            r_out.element_count <= ELEM_W'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // occupied cells form an unbroken run from the front
    `ASSERT_ALWAYS(a_cells_packed, i_clk, i_rst_n, ((valid_vec >> 1) & ~valid_vec) == '0)
    // count agrees with the occupied cells
    `ASSERT_ALWAYS(a_count_match, i_clk, i_rst_n, CNT_W'($countones(valid_vec)) == r_count)
    // an accepted transaction always leaves a result pending
    `ASSERT_NEXT(a_acc_pend, i_clk, i_rst_n, in_acc, r_pend)
    // a refused push is reported only at full occupancy
    `ASSERT_IMPLY(a_full_status, i_clk, i_rst_n, r_out_valid && (r_out.status == ST_FULL), r_out.element_count == ELEM_W'(DEPTH))

endmodule
